>>> rtl/core/asfs_pkg.sv
// ----------------------------------------------------------------------------
// asfs_pkg
// shared types and constants of the audio silence frame skipper: channel
// payloads, register indexes, reset values and the controller/datapath link
// ----------------------------------------------------------------------------
package asfs_pkg;

   // sample and register widths
   localparam int SAMPLE_W = 16;
   localparam int LEVEL_W  = 8;
   localparam int CSR_W    = 8;
   localparam int CSR_IDX_W = 1;

   // squared magnitude of a 16-bit sample is at most 2^30
   localparam int SQ_W = 31;

   // rms scale squared: 1000^2
   localparam int SCALE_W = 20;
   localparam logic [SCALE_W-1:0] RMS_SCALE_SQ = 20'd1000000;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_QUIET_LEVEL = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_HANGOVER    = 1'b1;

   // register reset values
   localparam logic [LEVEL_W-1:0] QUIET_LEVEL_RESET = 8'd10;
   localparam logic [LEVEL_W-1:0] HANGOVER_RESET    = 8'd25;

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] sample;
      logic                       last;
      logic                       bypass;
   } req_payload_type;

   typedef struct packed {
      logic skip_frame;
      logic key_frame;
   } rsp_payload_type;

   // datapath operations issued by the controller
   typedef enum logic [3:0] {
      OP_NONE,
      OP_FLUSH_CLR,
      OP_MUL_LC,
      OP_MUL_RHS,
      OP_MUL_PLO,
      OP_MUL_PHI,
      OP_SUM_LHS,
      OP_DECIDE
   } dp_op_type;

   typedef struct packed {
      logic      sample_take;
      dp_op_type op;
   } ctl_cmd_type;

   typedef struct packed {
      logic out_free;
   } dp_status_type;

endpackage

>>> rtl/core/asfs_ctrl.sv
// ----------------------------------------------------------------------------
// asfs_ctrl
// frame sequencer: accepts samples, then steps the datapath through the
// frame-end compare, held at decide by a full output, one operation per cycle
// ----------------------------------------------------------------------------
module asfs_ctrl (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   input  asfs_pkg::req_payload_type req_payload,
   output logic                     req_stall,
   input  asfs_pkg::dp_status_type  status,
   output asfs_pkg::ctl_cmd_type    cmd
);
   import asfs_pkg::*;

   typedef enum logic [2:0] {
      ST_ACCEPT,
      ST_FLUSH,
      ST_LC,
      ST_RHS,
      ST_PLO,
      ST_PHI,
      ST_LHS,
      ST_DECIDE
   } state_type;

   state_type state_ff, state_in;
   logic      bypass_ff, bypass_in;
   logic      take;

   assign req_stall = (state_ff != ST_ACCEPT);
   assign take      = (state_ff == ST_ACCEPT) && req_valid;

   always_comb begin
      state_in        = state_ff;
      bypass_in       = bypass_ff;
      cmd.sample_take = take;
      cmd.op          = OP_NONE;
      unique case (state_ff)
         ST_ACCEPT: begin
            if (take && req_payload.last) begin
               state_in  = ST_FLUSH;
               bypass_in = req_payload.bypass;
            end
         end
         // last square lands in the sum during this cycle
         ST_FLUSH: begin
            if (bypass_ff) begin
               cmd.op   = OP_FLUSH_CLR;
               state_in = ST_ACCEPT;
            end else begin
               state_in = ST_LC;
            end
         end
         ST_LC: begin
            cmd.op   = OP_MUL_LC;
            state_in = ST_RHS;
         end
         ST_RHS: begin
            cmd.op   = OP_MUL_RHS;
            state_in = ST_PLO;
         end
         ST_PLO: begin
            cmd.op   = OP_MUL_PLO;
            state_in = ST_PHI;
         end
         ST_PHI: begin
            cmd.op   = OP_MUL_PHI;
            state_in = ST_LHS;
         end
         ST_LHS: begin
            cmd.op   = OP_SUM_LHS;
            state_in = ST_DECIDE;
         end
         ST_DECIDE: begin
            if (status.out_free) begin
               cmd.op   = OP_DECIDE;
               state_in = ST_ACCEPT;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_ACCEPT;
         bypass_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         bypass_ff <= bypass_in;
      end
   end

endmodule

>>> rtl/core/asfs_datapath.sv
// ----------------------------------------------------------------------------
// asfs_datapath
// square and accumulate, shared multiplier for the frame-end compare,
// hangover counter and result register
// ----------------------------------------------------------------------------
module asfs_datapath #(
   parameter int MAX_FRAME_SAMPLES = 65536
) (
   input  logic                         clock,
   input  logic                         reset,
   input  asfs_pkg::req_payload_type    req_payload,
   input  logic                         csr_write_en,
   input  logic [asfs_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [asfs_pkg::CSR_W-1:0]   csr_write_data,
   input  asfs_pkg::ctl_cmd_type        cmd,
   output asfs_pkg::dp_status_type      status,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output asfs_pkg::rsp_payload_type    rsp_payload
);
   import asfs_pkg::*;

   localparam int CNT_W   = $clog2(MAX_FRAME_SAMPLES + 1);
   localparam int SUM_W   = SQ_W - 1 + CNT_W;
   localparam int H_W     = (SUM_W + 1) / 2;
   localparam int HI_W    = SUM_W - H_W;
   localparam int LC_W    = LEVEL_W + CNT_W;
   localparam int RHS_W   = 2 * LC_W;
   localparam int PLO_W   = H_W + SCALE_W;
   localparam int PHI_W   = HI_W + SCALE_W;
   localparam int LHS_W   = SUM_W + SCALE_W;
   localparam int OPND_A  = (LC_W > H_W) ? LC_W : H_W;
   localparam int OPND_W  = (OPND_A > SCALE_W) ? OPND_A : SCALE_W;
   localparam int PROD_W  = 2 * OPND_W;
   localparam int CMP_W   = (LHS_W > RHS_W) ? LHS_W : RHS_W;
   localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_FRAME_SAMPLES);

   logic [SUM_W-1:0]   sum_ff, sum_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic [SQ_W-1:0]    sq_ff, sq_in;
   logic               sq_pend_ff, sq_pend_in;
   logic [LEVEL_W-1:0] level_ff, level_in;
   logic [LEVEL_W-1:0] hangover_ff, hangover_in;
   logic [LEVEL_W-1:0] qcnt_ff, qcnt_in;
   logic               skipping_ff, skipping_in;
   logic [LC_W-1:0]    lc_ff, lc_in;
   logic [RHS_W-1:0]   rhs_ff, rhs_in;
   logic [PLO_W-1:0]   plo_ff, plo_in;
   logic [PHI_W-1:0]   phi_ff, phi_in;
   logic [LHS_W-1:0]   lhs_ff, lhs_in;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_payload_type    rsp_payload_ff, rsp_payload_in;

   logic [SAMPLE_W-1:0]   mag;
   logic [2*SAMPLE_W-1:0] sq_full;
   logic [OPND_W-1:0]     mul_a, mul_b;
   logic [PROD_W-1:0]     mul_p;
   logic                  quiet;

   assign mag     = req_payload.sample[SAMPLE_W-1] ?
                    (~req_payload.sample + 1'b1) : req_payload.sample;
   assign sq_full = mag * mag;

   // shared multiplier, one product per multiply step
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (cmd.op)
         OP_MUL_LC: begin
            mul_a = OPND_W'(level_ff);
            mul_b = OPND_W'(cnt_ff);
         end
         OP_MUL_RHS: begin
            mul_a = OPND_W'(lc_ff);
            mul_b = OPND_W'(lc_ff);
         end
         OP_MUL_PLO: begin
            mul_a = OPND_W'(sum_ff[H_W-1:0]);
            mul_b = OPND_W'(RMS_SCALE_SQ);
         end
         OP_MUL_PHI: begin
            mul_a = OPND_W'(sum_ff[SUM_W-1:H_W]);
            mul_b = OPND_W'(RMS_SCALE_SQ);
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign mul_p = mul_a * mul_b;
   assign quiet = CMP_W'(lhs_ff) < CMP_W'(rhs_ff);

   assign status.out_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      sum_in         = sum_ff;
      cnt_in         = cnt_ff;
      sq_in          = sq_ff;
      sq_pend_in     = 1'b0;
      level_in       = level_ff;
      hangover_in    = hangover_ff;
      qcnt_in        = qcnt_ff;
      skipping_in    = skipping_ff;
      lc_in          = lc_ff;
      rhs_in         = rhs_ff;
      plo_in         = plo_ff;
      phi_in         = phi_ff;
      lhs_in         = lhs_ff;
      rsp_valid_in   = rsp_valid_ff && rsp_stall;
      rsp_payload_in = rsp_payload_ff;

      // square registered at the transfer, added in the next cycle
      if (sq_pend_ff) begin
         sum_in = sum_ff + SUM_W'(sq_ff);
      end
      if (cmd.sample_take && !req_payload.bypass && (cnt_ff < MAX_CNT)) begin
         sq_in      = sq_full[SQ_W-1:0];
         sq_pend_in = 1'b1;
         cnt_in     = cnt_ff + 1'b1;
      end

      case (cmd.op)
         OP_FLUSH_CLR: begin
            sum_in = '0;
            cnt_in = '0;
         end
         OP_MUL_LC:  lc_in  = mul_p[LC_W-1:0];
         OP_MUL_RHS: rhs_in = mul_p[RHS_W-1:0];
         OP_MUL_PLO: plo_in = mul_p[PLO_W-1:0];
         OP_MUL_PHI: phi_in = mul_p[PHI_W-1:0];
         OP_SUM_LHS: lhs_in = LHS_W'(plo_ff) + (LHS_W'(phi_ff) << H_W);
         OP_DECIDE: begin
            sum_in                    = '0;
            cnt_in                    = '0;
            rsp_valid_in              = 1'b1;
            rsp_payload_in.skip_frame = 1'b0;
            rsp_payload_in.key_frame  = 1'b0;
            if (quiet) begin
               if (qcnt_ff == hangover_ff) begin
                  rsp_payload_in.skip_frame = 1'b1;
                  skipping_in               = 1'b1;
               end else begin
                  qcnt_in = qcnt_ff + 1'b1;
               end
            end else begin
               rsp_payload_in.key_frame = skipping_ff;
               skipping_in              = 1'b0;
               qcnt_in                  = '0;
            end
         end
         default: begin
         end
      endcase

      if (csr_write_en) begin
         unique case (csr_index)
            CSR_QUIET_LEVEL: level_in = csr_write_data;
            CSR_HANGOVER: begin
               hangover_in = csr_write_data;
               qcnt_in     = csr_write_data;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff       <= '0;
         cnt_ff       <= '0;
         sq_pend_ff   <= 1'b0;
         level_ff     <= QUIET_LEVEL_RESET;
         hangover_ff  <= HANGOVER_RESET;
         qcnt_ff      <= HANGOVER_RESET;
         skipping_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         sum_ff       <= sum_in;
         cnt_ff       <= cnt_in;
         sq_pend_ff   <= sq_pend_in;
         level_ff     <= level_in;
         hangover_ff  <= hangover_in;
         qcnt_ff      <= qcnt_in;
         skipping_ff  <= skipping_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      sq_ff          <= sq_in;
      lc_ff          <= lc_in;
      rhs_ff         <= rhs_in;
      plo_ff         <= plo_in;
      phi_ff         <= phi_in;
      lhs_ff         <= lhs_in;
      rsp_payload_ff <= rsp_payload_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

endmodule

>>> rtl/core/audio_silence_frame_skipper_top.sv
// ----------------------------------------------------------------------------
// audio_silence_frame_skipper_top
// rms silence detector with hangover: marks quiet audio frames for skipping
// ----------------------------------------------------------------------------
// usage
//   req channel: one signed 16-bit sample per transfer, with last on the
//     final sample of a frame and bypass for frames skipped upstream
//   rsp channel: one transfer per frame end without bypass, carrying
//     skip_frame and key_frame; bypassed frame ends give no transfer
//   csr port: write quiet_level (index 0) or hangover (index 1) while idle;
//     a hangover write also loads the quiet frame counter
// throughput and frame-end steps
//   samples transfer one per cycle within a frame; after the last sample of a
//   frame the input stalls while the frame-end compare runs through the
//   shared multiplier (a bypassed frame end stalls for the flush only): flush,
//   level*count, its square, two partial products of sum*10^6, their sum,
//   then compare and decide, the result registered in the decide step
// reset
//   synchronous, active high; sums cleared, quiet_level 10, hangover 25,
//   counter 25, not skipping
// backpressure
//   a stalled result holds in the output register; samples of the next frame
//   keep flowing, and the next frame end waits in its decide step until the
//   output register frees up
// ----------------------------------------------------------------------------
module audio_silence_frame_skipper_top #(
   parameter int MAX_FRAME_SAMPLES = 65536
) (
   input  logic                           clock,
   input  logic                           reset,
   // sample input
   input  logic                           req_valid,
   output logic                           req_stall,
   input  asfs_pkg::req_payload_type      req_payload,
   // frame result
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output asfs_pkg::rsp_payload_type      rsp_payload,
   // register writes
   input  logic                           csr_write_en,
   input  logic [asfs_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [asfs_pkg::CSR_W-1:0]     csr_write_data
);
   import asfs_pkg::*;

   // controller to datapath link
   ctl_cmd_type   cmd;
   dp_status_type status;

   // sequencer: sample transfers and the frame-end steps
   asfs_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_payload (req_payload),
      .req_stall   (req_stall),
      .status      (status),
      .cmd         (cmd)
   );

   // accumulators, compare arithmetic, hangover state and result register
   asfs_datapath #(
      .MAX_FRAME_SAMPLES (MAX_FRAME_SAMPLES)
   ) u_datapath (
      .clock          (clock),
      .reset          (reset),
      .req_payload    (req_payload),
      .csr_write_en   (csr_write_en),
      .csr_index      (csr_index),
      .csr_write_data (csr_write_data),
      .cmd            (cmd),
      .status         (status),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_payload    (rsp_payload)
   );

endmodule
